[src/nci_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, field widths and codes for the Newton-Cotes integrator.
// No dependencies.
package nci_pkg;

    localparam int LIMIT_W  = 24;
    localparam int COUNT_W  = 11;
    localparam int RULE_W   = 3;
    localparam int INTEG_W  = 19;
    localparam int STATUS_W = 2;

    localparam int MAX_INTERVALS_DEF = 1024;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int FVAL_BITS         = 30;

    // rule codes
    localparam logic [RULE_W-1:0] RULE_TRAP   = 3'd0;
    localparam logic [RULE_W-1:0] RULE_SIMP13 = 3'd1;
    localparam logic [RULE_W-1:0] RULE_SIMP38 = 3'd2;
    localparam logic [RULE_W-1:0] RULE_BOOLE  = 3'd3;
    localparam logic [RULE_W-1:0] RULE_WEDDLE = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_COUNT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_SAT       = 2'd2;

    localparam logic [INTEG_W-1:0] INTEG_MAX = 19'h3FFFF;
    localparam logic [INTEG_W-1:0] INTEG_MIN = 19'h40000;

endpackage

[src/nci_req_if.sv]
`timescale 1ns / 1ps
// Request channel: integration limits, interval count and rule code.
// Depends on nci_pkg.
interface nci_req_if import nci_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [LIMIT_W-1:0]  lower_limit;
    logic signed [LIMIT_W-1:0]  upper_limit;
    logic [COUNT_W-1:0]         interval_count;
    logic [RULE_W-1:0]          rule;

    modport source (output valid, lower_limit, upper_limit, interval_count, rule,
                    input ready);
    modport sink   (input valid, lower_limit, upper_limit, interval_count, rule,
                    output ready);
endinterface

[src/nci_rsp_if.sv]
`timescale 1ns / 1ps
// Response channel: integral estimate and status.
// Depends on nci_pkg.
interface nci_rsp_if import nci_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [INTEG_W-1:0]  integral;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, integral, status, input ready);
    modport sink   (input valid, integral, status, output ready);
endinterface

[src/newton_cotes_integrator_core.sv]
`timescale 1ns / 1ps
// Composite Newton-Cotes integrator of 1/(1+x^2), sequenced over one shared
// restoring divider and one shared multiplier. Depends on nci_pkg, nci_req_if, nci_rsp_if.
//
// Usage:
//   req carries one word: lower/upper limit (signed Q(24-FRAC_BITS).FRAC_BITS), interval
//   count n and rule code. rsp returns one word per request: integral
//   (signed, FRAC_BITS fraction bits, saturated) and status.
//   req.ready is high only while the block is idle; one request is worked
//   on at a time.
// Sequencing:
//   bad count or rule: rsp.valid rises in the next cycle.
//   otherwise each sample point is bound by the 31-step 2^62/d division
//   on the shared divider (one quotient bit a cycle), plus a squaring and
//   a weight multiply on the shared multiplier; the final mean division
//   yields NUM_W quotient bits (NUM_W is 64 at defaults).
// Reset (rst_n low, async) returns the sequencer to idle and drops rsp.valid;
//   any request in flight is lost.
// Stall: the result sits in output registers with rsp.valid high until
//   rsp.ready; no new request is taken before that.
module newton_cotes_integrator_core import nci_pkg::*; #(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    nci_req_if.sink   req,
    nci_rsp_if.source rsp
);

    // ---------------------------------------------------------------
    // Derived widths
    // ---------------------------------------------------------------
    localparam int IDX_W  = $clog2(MAX_INTERVALS + 1);
    localparam int CMP_W  = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
    localparam int SUM_W  = 36 + IDX_W;           // w*f <= 2^35, n+1 terms
    localparam int DSH    = 32 - 2 * FRAC_BITS;   // scale 1+x^2 to 32 frac bits
    localparam int LSH    = (DSH > 0) ? DSH : 0;
    localparam int RSH    = (DSH < 0) ? -DSH : 0;
    localparam int RND    = (RSH > 0) ? (1 << (RSH - 1)) : 0;
    localparam int D_W    = 52 + LSH;
    localparam int NUM_A  = (D_W + 2 > 64) ? D_W + 2 : 64;
    localparam int NUM_W  = (SUM_W + 3 > NUM_A) ? SUM_W + 3 : NUM_A;
    localparam int DIVW   = CMP_W + 6;            // n * 45
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int MAG_W  = LIMIT_W;
    localparam int OFF_W  = LIMIT_W + 1;
    localparam int X_W    = LIMIT_W + 2;
    localparam int AX_W   = LIMIT_W + 1;
    localparam int MA_W   = 32;
    localparam int MB_W   = AX_W;
    localparam int PROD_W = MA_W + MB_W;
    localparam int R_W    = PROD_W - FVAL_BITS;

    // quotient bits produced per division kind
    localparam int K_STEP = MAG_W;
    localparam int K_FVAL = 31;
    localparam int K_MEAN = NUM_W;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_DIVQ, S_SQ, S_FDIV, S_FWAIT, S_WMUL, S_ACC,
        S_MEAN0, S_MEAN1, S_MWAIT, S_FIN, S_RND, S_OUT
    } state_t;

    state_t                     state_reg;
    logic [CNT_W-1:0]           div_cnt_reg;
    logic signed [INTEG_W-1:0]  integral_reg;
    logic [STATUS_W-1:0]        status_reg;

    // request fields
    logic signed [LIMIT_W-1:0]  a_reg;
    logic signed [LIMIT_W-1:0]  b_reg;
    logic [COUNT_W-1:0]         n_reg;
    logic [RULE_W-1:0]          rule_reg;

    // datapath
    logic                       neg_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic [MAG_W-1:0]           qm_reg;       // mag / n
    logic [COUNT_W-1:0]         rm_reg;       // mag % n
    logic [OFF_W-1:0]           q_reg;        // sample offset
    logic [COUNT_W-1:0]         r_reg;        // offset remainder
    logic [IDX_W-1:0]           i_reg;
    logic [1:0]                 mod3_reg;
    logic [2:0]                 mod6_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [PROD_W-1:0]          prod_reg;

    // shared divider
    logic [D_W-1:0]             rem_reg;
    logic [NUM_W-1:0]           shn_reg;
    logic [NUM_W-1:0]           quo_reg;
    logic [D_W-1:0]             den_reg;

    // ---------------------------------------------------------------
    // Request check
    // ---------------------------------------------------------------
    function automatic logic mod3_zero(input logic [COUNT_W-1:0] v);
        logic [11:0] e;
        logic [4:0]  s;
        begin
            e = 12'(v);
            s = '0;
            // 4 == 1 mod 3: sum base-4 digits
            for (int k = 0; k < 6; k++)
            begin
                s = s + 5'(e[2*k +: 2]);
            end
            return (s == 5'd0) || (s == 5'd3) || (s == 5'd6) || (s == 5'd9) ||
                   (s == 5'd12) || (s == 5'd15) || (s == 5'd18);
        end
    endfunction

    logic req_bad;
    logic rule_ok;

    always_comb
    begin
        unique case (req.rule)
            RULE_TRAP:   rule_ok = 1'b1;
            RULE_SIMP13: rule_ok = ~req.interval_count[0];
            RULE_SIMP38: rule_ok = mod3_zero(req.interval_count);
            RULE_BOOLE:  rule_ok = (req.interval_count[1:0] == 2'b00);
            RULE_WEDDLE: rule_ok = ~req.interval_count[0] & mod3_zero(req.interval_count);
            default:     rule_ok = 1'b0;
        endcase
        req_bad = (req.interval_count == '0) ||
                  (32'(req.interval_count) > 32'(MAX_INTERVALS)) || !rule_ok;
    end

    // ---------------------------------------------------------------
    // Point arithmetic
    // ---------------------------------------------------------------
    logic signed [OFF_W-1:0] diff;
    logic [MAG_W-1:0]        mag;
    logic signed [X_W-1:0]   x;
    logic [AX_W-1:0]         ax;
    logic [D_W-1:0]          d_raw;
    logic [D_W-1:0]          d_val;
    logic                    i_end;
    logic [5:0]              w;
    logic [COUNT_W:0]        r_sum;
    logic                    r_wrap;

    always_comb
    begin
        diff  = OFF_W'(b_reg) - OFF_W'(a_reg);
        mag   = diff[OFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        x     = neg_reg ? (X_W'(a_reg) - X_W'(q_reg)) : (X_W'(a_reg) + X_W'(q_reg));
        ax    = x[X_W-1] ? AX_W'(-x) : AX_W'(x);
        d_raw = (D_W'(1) << (2 * FRAC_BITS)) + D_W'(prod_reg[2*AX_W-1:0]);
        d_val = ((d_raw + D_W'(RND)) >> RSH) << LSH;
        i_end = (CMP_W'(i_reg) == '0) || (CMP_W'(i_reg) == CMP_W'(n_reg));
        r_sum = (COUNT_W+1)'(r_reg) + (COUNT_W+1)'(rm_reg);
        r_wrap = (r_sum >= (COUNT_W+1)'(n_reg));
    end

    always_comb
    begin
        if (i_end)
        begin
            w = (rule_reg == RULE_BOOLE) ? 6'd7 : 6'd1;
        end
        else
        begin
            unique case (rule_reg)
                RULE_TRAP:   w = 6'd2;
                RULE_SIMP13: w = i_reg[0] ? 6'd4 : 6'd2;
                RULE_SIMP38: w = (mod3_reg == 2'd0) ? 6'd2 : 6'd3;
                RULE_BOOLE:  w = i_reg[0] ? 6'd32 : (i_reg[1] ? 6'd12 : 6'd14);
                default:
                begin
                    unique case (mod6_reg)
                        3'd1, 3'd5: w = 6'd5;
                        3'd2, 3'd4: w = 6'd1;
                        3'd3:       w = 6'd6;
                        default:    w = 6'd2;
                    endcase
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Shared multiplier (registered product)
    // ---------------------------------------------------------------
    logic [MA_W-1:0] mul_a;
    logic [MB_W-1:0] mul_b;
    logic            mul_en;
    logic [5:0]      rule_den;
    logic            rule_x3;
    logic            rule_x2;

    always_comb
    begin
        unique case (rule_reg)
            RULE_TRAP:   rule_den = 6'd2;
            RULE_SIMP13: rule_den = 6'd3;
            RULE_SIMP38: rule_den = 6'd8;
            RULE_BOOLE:  rule_den = 6'd45;
            default:     rule_den = 6'd10;
        endcase
        rule_x3 = (rule_reg == RULE_SIMP38) || (rule_reg == RULE_WEDDLE);
        rule_x2 = (rule_reg == RULE_BOOLE);
    end

    always_comb
    begin
        mul_en = 1'b1;
        unique case (state_reg)
            S_SQ:
            begin
                mul_a = MA_W'(ax);
                mul_b = ax;
            end
            S_WMUL:
            begin
                mul_a = quo_reg[MA_W-1:0];
                mul_b = MB_W'(w);
            end
            S_MEAN0:
            begin
                mul_a = MA_W'(n_reg);
                mul_b = MB_W'(rule_den);
            end
            S_FIN:
            begin
                mul_a = quo_reg[MA_W-1:0];
                mul_b = MB_W'(mag_reg);
            end
            default:
            begin
                mul_en = 1'b0;
                mul_a  = '0;
                mul_b  = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Shared divider: start selection and one restoring step
    // ---------------------------------------------------------------
    logic                div_start;
    logic [NUM_W-1:0]    div_num;
    logic [D_W-1:0]      div_den;
    logic [CNT_W-1:0]    div_k;
    logic [DIVW-1:0]     mean_div;
    logic [D_W+1:0]      trial;
    logic                trial_ge;

    always_comb
    begin
        mean_div  = prod_reg[DIVW-1:0];
        div_start = 1'b1;
        unique case (state_reg)
            S_PREP:
            begin
                div_num = NUM_W'(mag);
                div_den = D_W'(n_reg);
                div_k   = CNT_W'(K_STEP);
            end
            S_FDIV:
            begin
                div_num = (NUM_W'(1) << 62) + NUM_W'(d_val >> 1);
                div_den = d_val;
                div_k   = CNT_W'(K_FVAL);
            end
            S_MEAN1:
            begin
                // sum times rule numerator (1, 2 or 3), plus half the divisor
                div_num = NUM_W'(sum_reg) + (rule_x3 ? (NUM_W'(sum_reg) << 1) : '0) +
                          (rule_x2 ? NUM_W'(sum_reg) : '0) +
                          NUM_W'(mean_div >> 1);
                div_den = D_W'(mean_div);
                div_k   = CNT_W'(K_MEAN);
            end
            default:
            begin
                div_start = 1'b0;
                div_num   = '0;
                div_den   = '0;
                div_k     = '0;
            end
        endcase
        trial    = {1'b0, rem_reg, shn_reg[NUM_W-1]} - {2'b00, den_reg};
        trial_ge = ~trial[D_W+1];
    end

    // ---------------------------------------------------------------
    // Sequencer and output registers
    // ---------------------------------------------------------------
    logic [PROD_W-1:0] rnd_sum;
    logic [R_W-1:0]    r_mag;

    always_comb
    begin
        rnd_sum = prod_reg + (PROD_W'(1) << (FVAL_BITS - 1));
        r_mag   = rnd_sum[PROD_W-1:FVAL_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            div_cnt_reg  <= '0;
            integral_reg <= '0;
            status_reg   <= STAT_OK;
        end
        else
        begin
            if (div_start)
            begin
                div_cnt_reg <= div_k;
            end
            else if (div_cnt_reg != '0)
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        if (req_bad)
                        begin
                            integral_reg <= '0;
                            status_reg   <= STAT_BAD_COUNT;
                            state_reg    <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_PREP;
                        end
                    end
                end
                S_PREP:  state_reg <= S_DIVQ;
                S_DIVQ:  if (div_cnt_reg == '0) state_reg <= S_SQ;
                S_SQ:    state_reg <= S_FDIV;
                S_FDIV:  state_reg <= S_FWAIT;
                S_FWAIT: if (div_cnt_reg == '0) state_reg <= S_WMUL;
                S_WMUL:  state_reg <= S_ACC;
                S_ACC:
                begin
                    if (CMP_W'(i_reg) == CMP_W'(n_reg))
                    begin
                        state_reg <= S_MEAN0;
                    end
                    else
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_MEAN0: state_reg <= S_MEAN1;
                S_MEAN1: state_reg <= S_MWAIT;
                S_MWAIT: if (div_cnt_reg == '0) state_reg <= S_FIN;
                S_FIN:   state_reg <= S_RND;
                S_RND:
                begin
                    // clamp magnitude, then apply sign of (b - a)
                    if (!neg_reg && (r_mag > R_W'(INTEG_MAX)))
                    begin
                        integral_reg <= INTEG_MAX;
                        status_reg   <= STAT_SAT;
                    end
                    else if (neg_reg && (r_mag > R_W'(INTEG_MIN)))
                    begin
                        integral_reg <= INTEG_MIN;
                        status_reg   <= STAT_SAT;
                    end
                    else
                    begin
                        integral_reg <= neg_reg ? -INTEG_W'(r_mag) : INTEG_W'(r_mag);
                        status_reg   <= STAT_OK;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:   if (rsp.ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end

        if (div_start)
        begin
            rem_reg <= D_W'(div_num >> div_k);
            shn_reg <= div_num << (CNT_W'(NUM_W) - div_k);
            den_reg <= div_den;
            quo_reg <= '0;
        end
        else if (div_cnt_reg != '0)
        begin
            rem_reg <= trial_ge ? trial[D_W-1:0] : {rem_reg[D_W-2:0], shn_reg[NUM_W-1]};
            shn_reg <= shn_reg << 1;
            quo_reg <= {quo_reg[NUM_W-2:0], trial_ge};
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    a_reg    <= req.lower_limit;
                    b_reg    <= req.upper_limit;
                    n_reg    <= req.interval_count;
                    rule_reg <= req.rule;
                end
            end
            S_PREP:
            begin
                neg_reg  <= diff[OFF_W-1];
                mag_reg  <= mag;
                i_reg    <= '0;
                mod3_reg <= '0;
                mod6_reg <= '0;
                q_reg    <= '0;
                r_reg    <= n_reg >> 1;
                sum_reg  <= '0;
            end
            S_DIVQ:
            begin
                qm_reg <= quo_reg[MAG_W-1:0];
                rm_reg <= rem_reg[COUNT_W-1:0];
            end
            S_ACC:
            begin
                sum_reg  <= sum_reg + SUM_W'(prod_reg);
                i_reg    <= i_reg + 1'b1;
                mod3_reg <= (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
                mod6_reg <= (mod6_reg == 3'd5) ? 3'd0 : mod6_reg + 3'd1;
                // offset of next point: round(mag*(i+1)/n) kept as quotient/remainder
                q_reg    <= q_reg + OFF_W'(qm_reg) + OFF_W'(r_wrap);
                r_reg    <= r_wrap ? COUNT_W'(r_sum - (COUNT_W+1)'(n_reg))
                                   : COUNT_W'(r_sum);
            end
            default:
            begin
            end
        endcase
    end

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = (state_reg == S_OUT);
    assign rsp.integral = integral_reg;
    assign rsp.status   = status_reg;

endmodule
